/* sv/kcs_pkg.sv */
// kcs_pkg: shared types and codes for the keyword category spotter.
// Used by kcs_front, kcs_queue, kcs_back and the top level; depends on nothing.
package kcs_pkg;

  localparam int FUNC_W = 2;
  localparam int IDX_W  = 4;
  localparam int POS_W  = 5;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 6;
  localparam int CAT_W  = 4;
  localparam int SEEN_W = 1 << CAT_W;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COMMIT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHAR   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_END    = 2'd3;

  localparam logic [CHAR_W-1:0] SEP_CHAR = 8'd32;

  // classified operations handed from front to back
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [OP_W-1:0] OP_COMMIT = 3'd1;
  localparam logic [OP_W-1:0] OP_CHAR   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEP    = 3'd3;
  localparam logic [OP_W-1:0] OP_END    = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] chr;
    logic [LEN_W-1:0]  len;
    logic [CAT_W-1:0]  cat;
  } item_t;

  typedef struct packed {
    logic [CAT_W-1:0] cat;
    logic             has;
    logic             done;
    logic             none;
    logic             last;
  } result_t;

endpackage

/* sv/kcs_front.sv */
// kcs_front: accepts input transactions, classifies them, drops loads and commits outside the store.
// Depends on kcs_pkg.
module kcs_front #(
  parameter int MAX_WORDS      = 16,
  parameter int WORD_CHARS     = 32,
  parameter int NUM_CATEGORIES = 16
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kcs_pkg::FUNC_W-1:0]  func,
  input  logic [kcs_pkg::IDX_W-1:0]   entry_index,
  input  logic [kcs_pkg::POS_W-1:0]   char_pos,
  input  logic [kcs_pkg::CHAR_W-1:0]  char_value,
  input  logic [kcs_pkg::LEN_W-1:0]   word_length,
  input  logic [kcs_pkg::CAT_W-1:0]   category_in,
  input  logic                        q_full,
  output logic                        push,
  output kcs_pkg::item_t              push_item
);

  logic keep;

  always_comb begin
    keep            = 1'b1;
    push_item.op    = kcs_pkg::OP_END;
    push_item.idx   = entry_index;
    push_item.pos   = char_pos;
    push_item.chr   = char_value;
    push_item.len   = word_length;
    push_item.cat   = category_in;
    unique case (func)
      kcs_pkg::FUNC_LOAD: begin
        push_item.op = kcs_pkg::OP_LOAD;
        keep = (int'(entry_index) < MAX_WORDS) && (int'(char_pos) < WORD_CHARS);
      end
      kcs_pkg::FUNC_COMMIT: begin
        push_item.op = kcs_pkg::OP_COMMIT;
        keep = int'(entry_index) < MAX_WORDS;
        // saturate categories beyond the configured range
        if (int'(category_in) > NUM_CATEGORIES - 1) begin
          push_item.cat = kcs_pkg::CAT_W'(NUM_CATEGORIES - 1);
        end
      end
      kcs_pkg::FUNC_CHAR: begin
        push_item.op = (char_value == kcs_pkg::SEP_CHAR) ? kcs_pkg::OP_SEP : kcs_pkg::OP_CHAR;
      end
      default: begin
        push_item.op = kcs_pkg::OP_END;
      end
    endcase
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && keep;

endmodule

/* sv/kcs_queue.sv */
// kcs_queue: short FIFO of classified operations between front and back.
// Depends on kcs_pkg.
module kcs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kcs_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output kcs_pkg::item_t head,
  output logic           empty
);

  kcs_pkg::item_t                slots [kcs_pkg::QUEUE_DEPTH];
  logic [kcs_pkg::QPTR_W-1:0]    wr_ptr;
  logic [kcs_pkg::QPTR_W-1:0]    rd_ptr;
  logic [kcs_pkg::QCNT_W-1:0]    count;

  assign full  = count == kcs_pkg::QCNT_W'(kcs_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + kcs_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + kcs_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + kcs_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - kcs_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* sv/kcs_back.sv */
// kcs_back: word store, entry table, token matching and result output register.
// Depends on kcs_pkg; fed by kcs_queue.
module kcs_back #(
  parameter int MAX_WORDS  = 16,
  parameter int WORD_CHARS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  kcs_pkg::item_t   q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output kcs_pkg::result_t out_res
);

  localparam int EW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_W = $clog2(MAX_WORDS + 1);
  localparam int PW    = $clog2(WORD_CHARS);
  localparam int TL_W  = $clog2(WORD_CHARS + 1);
  localparam int CMP_W = 8;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CMP       = 3'd1;
  localparam logic [2:0] S_PICK      = 3'd2;
  localparam logic [2:0] S_EMIT_CAT  = 3'd3;
  localparam logic [2:0] S_EMIT_DONE = 3'd4;

  // word store: one row per character position, one byte lane per entry
  logic [MAX_WORDS-1:0][kcs_pkg::CHAR_W-1:0] mem [WORD_CHARS];
  logic [MAX_WORDS-1:0][kcs_pkg::CHAR_W-1:0] rdata;

  logic [kcs_pkg::LEN_W-1:0] entry_len [MAX_WORDS];
  logic [kcs_pkg::CAT_W-1:0] entry_cat [MAX_WORDS];

  logic [2:0]                  state;
  logic [CNT_W-1:0]            entry_count;
  logic [MAX_WORDS-1:0]        flags;
  logic [TL_W-1:0]             token_length;
  logic                        token_overflow;
  logic [kcs_pkg::SEEN_W-1:0]  seen;
  logic [MAX_WORDS-1:0]        cand;
  logic                        is_end;
  logic [kcs_pkg::CHAR_W-1:0]  cur_chr;
  logic [kcs_pkg::CAT_W-1:0]   cat_reg;

  logic [MAX_WORDS-1:0]        cand_next;
  logic [MAX_WORDS-1:0]        flags_next;
  logic [EW-1:0]               pick_idx;
  logic                        pick_any;
  logic [kcs_pkg::CAT_W-1:0]   pick_cat;
  logic                        new_cat;
  logic                        slot_free;
  logic                        emit;
  logic                        tok_full;
  logic                        commit_ok;
  logic                        commit_append;
  logic [EW-1:0]               head_lane;
  logic [PW-1:0]               head_row;
  logic [PW-1:0]               tok_row;

  assign q_pop         = (state == S_IDLE) && !q_empty;
  assign slot_free     = !out_valid || !out_stall;
  assign emit          = slot_free && ((state == S_EMIT_CAT) || (state == S_EMIT_DONE));
  assign tok_full      = int'(token_length) >= WORD_CHARS;
  assign head_lane     = EW'(q_head.idx);
  assign head_row      = PW'(q_head.pos);
  assign tok_row       = token_length[PW-1:0];
  assign commit_ok     = int'(q_head.idx) <= int'(entry_count);
  assign commit_append = int'(q_head.idx) == int'(entry_count);

  // per-entry candidates at token end
  always_comb begin
    for (int i = 0; i < MAX_WORDS; i++) begin
      cand_next[i] = flags[i] && (token_length != '0) && !token_overflow &&
                     (CMP_W'(entry_len[i]) == CMP_W'(token_length)) &&
                     (i < int'(entry_count));
      flags_next[i] = flags[i] && (rdata[i] == cur_chr);
    end
  end

  // lowest-numbered candidate wins
  always_comb begin
    pick_idx = '0;
    pick_any = 1'b0;
    for (int i = MAX_WORDS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick_idx = EW'(i);
        pick_any = 1'b1;
      end
    end
    pick_cat = entry_cat[pick_idx];
    new_cat  = pick_any && !seen[pick_cat];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == kcs_pkg::OP_LOAD) begin
      mem[head_row][head_lane] <= q_head.chr;
    end
    if (q_pop && q_head.op == kcs_pkg::OP_CHAR && !tok_full) begin
      rdata <= mem[tok_row];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == kcs_pkg::OP_COMMIT && commit_ok) begin
      entry_len[head_lane] <= q_head.len;
      entry_cat[head_lane] <= q_head.cat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entry_count    <= '0;
      flags          <= '1;
      token_length   <= '0;
      token_overflow <= 1'b0;
      seen           <= '0;
      out_valid      <= 1'b0;
    end else begin
      // load a new result, drop a taken one, hold a stalled one
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            unique case (q_head.op)
              kcs_pkg::OP_COMMIT: begin
                if (commit_ok && commit_append) begin
                  entry_count <= entry_count + CNT_W'(1);
                end
              end
              kcs_pkg::OP_CHAR: begin
                cur_chr <= q_head.chr;
                if (tok_full) begin
                  token_overflow <= 1'b1;
                end else begin
                  state <= S_CMP;
                end
              end
              kcs_pkg::OP_SEP, kcs_pkg::OP_END: begin
                cand   <= cand_next;
                is_end <= q_head.op == kcs_pkg::OP_END;
                state  <= S_PICK;
              end
              default: begin
              end
            endcase
          end
        end
        S_CMP: begin
          flags        <= flags_next;
          token_length <= token_length + TL_W'(1);
          state        <= S_IDLE;
        end
        S_PICK: begin
          cat_reg        <= pick_cat;
          flags          <= '1;
          token_length   <= '0;
          token_overflow <= 1'b0;
          if (new_cat) begin
            seen[pick_cat] <= 1'b1;
            state          <= S_EMIT_CAT;
          end else if (is_end) begin
            state <= S_EMIT_DONE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT_CAT: begin
          if (slot_free) begin
            out_res.cat  <= cat_reg;
            out_res.has  <= 1'b1;
            out_res.done <= 1'b0;
            out_res.none <= 1'b0;
            out_res.last <= !is_end;
            state        <= is_end ? S_EMIT_DONE : S_IDLE;
          end
        end
        S_EMIT_DONE: begin
          if (slot_free) begin
            out_res.cat  <= '0;
            out_res.has  <= 1'b0;
            out_res.done <= 1'b1;
            out_res.none <= seen == '0;
            out_res.last <= 1'b1;
            seen         <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/keyword_category_spotter.sv */
// Keyword category spotter. The back end handles load and commit in its idle state,
// a message character through its compare state, and a separator or end of message
// through its pick state and then one emit state per result. The back end state machine
// and its single word-store read port set the rate. The 4-entry queue takes input while
// the back end works. Reset clears control, counts, match flags and the seen mask; the
// word store and entry table are not cleared and need no clearing pass.
module keyword_category_spotter #(
  parameter int MAX_WORDS      = 16,
  parameter int WORD_CHARS     = 32,
  parameter int NUM_CATEGORIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kcs_pkg::FUNC_W-1:0]  func,
  input  logic [kcs_pkg::IDX_W-1:0]   entry_index,
  input  logic [kcs_pkg::POS_W-1:0]   char_pos,
  input  logic [kcs_pkg::CHAR_W-1:0]  char_value,
  input  logic [kcs_pkg::LEN_W-1:0]   word_length,
  input  logic [kcs_pkg::CAT_W-1:0]   category_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kcs_pkg::CAT_W-1:0]   category_out,
  output logic                        has_category,
  output logic                        message_done,
  output logic                        none_found,
  output logic                        last
);

  logic             push;
  kcs_pkg::item_t   push_item;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  kcs_pkg::item_t   q_head;
  kcs_pkg::result_t out_res;

  kcs_front #(
    .MAX_WORDS      (MAX_WORDS),
    .WORD_CHARS     (WORD_CHARS),
    .NUM_CATEGORIES (NUM_CATEGORIES)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .entry_index (entry_index),
    .char_pos    (char_pos),
    .char_value  (char_value),
    .word_length (word_length),
    .category_in (category_in),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  kcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  kcs_back #(
    .MAX_WORDS  (MAX_WORDS),
    .WORD_CHARS (WORD_CHARS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign category_out = out_res.cat;
  assign has_category = out_res.has;
  assign message_done = out_res.done;
  assign none_found   = out_res.none;
  assign last         = out_res.last;

endmodule

/* sv/kcs_checker.sv */
// kcs_checker: port-level checks on the spotter's result channel, bound to the top level.
// Depends on kcs_pkg and keyword_category_spotter.
module kcs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [kcs_pkg::CAT_W-1:0] category_out,
  input logic                      has_category,
  input logic                      message_done,
  input logic                      none_found,
  input logic                      last
);

  // hold a stalled result transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(category_out) && $stable(has_category) &&
      $stable(message_done) && $stable(none_found) && $stable(last))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> has_category != message_done)
    else $error("result is neither a category nor a done result");

  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_done |-> last && category_out == '0)
    else $error("done result not final or carries a category");

  a_cat: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_category |-> !none_found)
    else $error("category result flags none found");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keyword_category_spotter kcs_checker u_kcs_checker (.*);
